>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, off while reset is low.
`define FCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on the same edge.
`define FCP_ASSERT_IMP(label, pre, post, msg) \
  `FCP_ASSERT(label, (pre) |-> (post), msg)

`endif

>>> hdl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// Types, grid constants and tables of the frontier colour placement block.
// ----------------------------------------------------------------------------
package fcp_pkg;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int CELLS  = GRID_W * GRID_H;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int X_W    = $clog2(GRID_W);
  localparam int Y_W    = $clog2(GRID_H);
  localparam int POS_W  = 6;
  localparam int SUM_W  = 21;
  localparam int REC_W  = 25;
  localparam int REC_SH = 24;
  localparam int PROD_W = SUM_W + REC_W;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [23:0]      placed_color;
    logic             placed;
  } out_t;

  // One grid entry: flags and stored colour.
  typedef struct packed {
    logic        open;
    logic        filled;
    logic [23:0] color;
  } cell_t;

  // Neighbour offsets, raster order round the centre.
  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  // floor(2^24 / c) + 1: exact floor division for sums below 2^21.
  function automatic logic [REC_W-1:0] recip(input logic [3:0] c);
    logic [REC_W-1:0] r;
    unique case (c)
      4'd1:    r = 25'd16777217;
      4'd2:    r = 25'd8388609;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194305;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097153;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/fcp_ram.sv
// ----------------------------------------------------------------------------
// fcp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/frontier_color_placement.sv
// ----------------------------------------------------------------------------
// frontier_color_placement
// Places a stream of colours on a grid, each at the open pixel whose filled
// neighbours are closest in mean squared RGB distance.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o | fcp_pkg::in_t  (red, green, blue)
//  out     | output    | out_valid_o/out_ready_i | fcp_pkg::out_t (pos, colour, placed)
//
// After reset a clearing pass writes all CELLS (4096) grid entries with
// in_ready_o low. Each item after the first scans the grid through the
// single read port, reading each pixel and, if open, its 8 neighbours, then
// a divide and compare; the best open pixel takes it and its neighbours open,
// else it is dropped. A waiting result holds the block in its final state.
module frontier_color_placement (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fcp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fcp_pkg::out_t out_data_o
);

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b0000_0000_0001,
    ST_IDLE     = 12'b0000_0000_0010,
    ST_SCAN_RD  = 12'b0000_0000_0100,
    ST_SCAN_CHK = 12'b0000_0000_1000,
    ST_NB_RD    = 12'b0000_0001_0000,
    ST_NB_ACC   = 12'b0000_0010_0000,
    ST_DIV      = 12'b0000_0100_0000,
    ST_CMP      = 12'b0000_1000_0000,
    ST_PLACE    = 12'b0001_0000_0000,
    ST_OPN_RD   = 12'b0010_0000_0000,
    ST_OPN_WR   = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_e;

  localparam logic [fcp_pkg::X_W-1:0] CX = fcp_pkg::X_W'(fcp_pkg::GRID_W / 2);
  localparam logic [fcp_pkg::Y_W-1:0] CY = fcp_pkg::Y_W'(fcp_pkg::GRID_H / 2);

  state_e                         state_q, state_d;
  logic [fcp_pkg::IDX_W-1:0]      clr_q, clr_d;
  logic                           seeded_q, seeded_d;
  fcp_pkg::in_t                   col_q, col_d;
  logic [fcp_pkg::X_W-1:0]        cx_q, cx_d, bx_q, bx_d;
  logic [fcp_pkg::Y_W-1:0]        cy_q, cy_d, by_q, by_d;
  logic                           found_q, found_d;
  logic [fcp_pkg::SUM_W-1:0]      best_q, best_d, sum_q, sum_d;
  logic [2:0]                     k_q, k_d;
  logic [3:0]                     cnt_q, cnt_d;
  logic [fcp_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic                           nb_ok_q, nb_ok_d;
  logic [fcp_pkg::IDX_W-1:0]      nb_addr_q, nb_addr_d;
  logic                           out_valid_q, out_valid_d;
  fcp_pkg::out_t                  out_q, out_d;

  logic                           ram_we;
  logic [fcp_pkg::IDX_W-1:0]      ram_waddr, ram_raddr;
  fcp_pkg::cell_t                 ram_wcell, rcell;
  logic [$bits(fcp_pkg::cell_t)-1:0] ram_rdata;

  logic signed [fcp_pkg::X_W+1:0] nx;
  logic signed [fcp_pkg::Y_W+1:0] ny;
  logic                           nb_ok;
  logic [fcp_pkg::IDX_W-1:0]      nb_addr, cur_addr, best_addr;
  logic                           last_cell;
  logic signed [8:0]              dr, dg, db;
  logic signed [17:0]             pr, pg, pb;
  logic [17:0]                    sq_dist;
  logic [fcp_pkg::SUM_W-1:0]      score;

  fcp_ram #(
    .WIDTH($bits(fcp_pkg::cell_t)),
    .DEPTH(fcp_pkg::CELLS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wcell),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rcell = fcp_pkg::cell_t'(ram_rdata);

  // Neighbour k of the current pixel, bounds and address
  always_comb begin
    nx = $signed({2'b00, cx_q}) + (fcp_pkg::X_W+2)'(fcp_pkg::nb_dx(k_q));
    ny = $signed({2'b00, cy_q}) + (fcp_pkg::Y_W+2)'(fcp_pkg::nb_dy(k_q));
    nb_ok = (nx >= 0) && (nx < $signed((fcp_pkg::X_W+2)'(fcp_pkg::GRID_W))) &&
            (ny >= 0) && (ny < $signed((fcp_pkg::Y_W+2)'(fcp_pkg::GRID_H)));
    nb_addr = fcp_pkg::IDX_W'(ny[fcp_pkg::Y_W-1:0]) * fcp_pkg::IDX_W'(fcp_pkg::GRID_W) +
              fcp_pkg::IDX_W'(nx[fcp_pkg::X_W-1:0]);
  end

  assign cur_addr  = fcp_pkg::IDX_W'(cy_q) * fcp_pkg::IDX_W'(fcp_pkg::GRID_W) +
                     fcp_pkg::IDX_W'(cx_q);
  assign best_addr = fcp_pkg::IDX_W'(by_q) * fcp_pkg::IDX_W'(fcp_pkg::GRID_W) +
                     fcp_pkg::IDX_W'(bx_q);
  assign last_cell = (cx_q == fcp_pkg::X_W'(fcp_pkg::GRID_W - 1)) &&
                     (cy_q == fcp_pkg::Y_W'(fcp_pkg::GRID_H - 1));

  // Squared distance of the read neighbour to the item colour
  always_comb begin
    dr = $signed({1'b0, rcell.color[23:16]}) - $signed({1'b0, col_q.red});
    dg = $signed({1'b0, rcell.color[15:8]})  - $signed({1'b0, col_q.green});
    db = $signed({1'b0, rcell.color[7:0]})   - $signed({1'b0, col_q.blue});
    pr = dr * dr;
    pg = dg * dg;
    pb = db * db;
    sq_dist = 18'(pr[16:0]) + 18'(pg[16:0]) + 18'(pb[16:0]);
  end

  assign score = prod_q[fcp_pkg::REC_SH +: fcp_pkg::SUM_W];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    seeded_d    = seeded_q;
    col_d       = col_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    bx_d        = bx_q;
    by_d        = by_q;
    found_d     = found_q;
    best_d      = best_q;
    sum_d       = sum_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    nb_ok_d     = nb_ok_q;
    nb_addr_d   = nb_addr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = nb_addr_q;
    ram_wcell   = '0;
    ram_raddr   = cur_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == fcp_pkg::IDX_W'(fcp_pkg::CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          col_d = in_data_i;
          if (!seeded_q) begin
            bx_d    = CX;
            by_d    = CY;
            found_d = 1'b1;
            state_d = ST_PLACE;
          end else begin
            cx_d    = '0;
            cy_d    = '0;
            found_d = 1'b0;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rcell.open) begin
          k_d     = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = ST_NB_RD;
        end else if (last_cell) begin
          state_d = found_q ? ST_PLACE : ST_DONE;
        end else begin
          if (cx_q == fcp_pkg::X_W'(fcp_pkg::GRID_W - 1)) begin
            cx_d = '0;
            cy_d = cy_q + 1'b1;
          end else begin
            cx_d = cx_q + 1'b1;
          end
          state_d = ST_SCAN_RD;
        end
      end
      ST_NB_RD: begin
        ram_raddr = nb_addr;
        nb_ok_d   = nb_ok;
        state_d   = ST_NB_ACC;
      end
      ST_NB_ACC: begin
        if (nb_ok_q && rcell.filled) begin
          sum_d = sum_q + fcp_pkg::SUM_W'(sq_dist);
          cnt_d = cnt_q + 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = (k_q == 3'd7) ? ST_DIV : ST_NB_RD;
      end
      ST_DIV: begin
        prod_d  = fcp_pkg::PROD_W'(sum_q) * fcp_pkg::PROD_W'(fcp_pkg::recip(cnt_q));
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // Strict compare keeps the lowest raster index on ties
        if (!found_q || (score < best_q)) begin
          found_d = 1'b1;
          best_d  = score;
          bx_d    = cx_q;
          by_d    = cy_q;
        end
        if (last_cell) begin
          state_d = ST_PLACE;
        end else begin
          if (cx_q == fcp_pkg::X_W'(fcp_pkg::GRID_W - 1)) begin
            cx_d = '0;
            cy_d = cy_q + 1'b1;
          end else begin
            cx_d = cx_q + 1'b1;
          end
          state_d = ST_SCAN_RD;
        end
      end
      ST_PLACE: begin
        ram_we           = 1'b1;
        ram_waddr        = best_addr;
        ram_wcell.open   = 1'b0;
        ram_wcell.filled = 1'b1;
        ram_wcell.color  = col_q;
        seeded_d         = 1'b1;
        cx_d             = bx_q;
        cy_d             = by_q;
        k_d              = '0;
        state_d          = ST_OPN_RD;
      end
      ST_OPN_RD: begin
        ram_raddr = nb_addr;
        nb_ok_d   = nb_ok;
        nb_addr_d = nb_addr;
        state_d   = ST_OPN_WR;
      end
      ST_OPN_WR: begin
        // Open an empty neighbour, keep its stored colour
        if (nb_ok_q && !rcell.filled) begin
          ram_we           = 1'b1;
          ram_wcell.open   = 1'b1;
          ram_wcell.filled = 1'b0;
          ram_wcell.color  = rcell.color;
        end
        k_d     = k_q + 1'b1;
        state_d = (k_q == 3'd7) ? ST_DONE : ST_OPN_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            out_d.pos_x        = fcp_pkg::POS_W'(bx_q);
            out_d.pos_y        = fcp_pkg::POS_W'(by_q);
            out_d.placed_color = col_q;
            out_d.placed       = 1'b1;
          end else begin
            out_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      seeded_q    <= 1'b0;
      col_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      sum_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      nb_ok_q     <= 1'b0;
      nb_addr_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      seeded_q    <= seeded_d;
      col_q       <= col_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      bx_q        <= bx_d;
      by_q        <= by_d;
      found_q     <= found_d;
      best_q      <= best_d;
      sum_q       <= sum_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      prod_q      <= prod_d;
      nb_ok_q     <= nb_ok_d;
      nb_addr_q   <= nb_addr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/fcp_checker.sv
// ----------------------------------------------------------------------------
// fcp_checker
// Port-level checks of the frontier colour placement block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input fcp_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fcp_pkg::out_t out_data_o
);

  // Hold a stalled result
  `FCP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Hold a waiting item
  `FCP_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i), "item changed while waiting")

  // Take one item at a time
  `FCP_ASSERT(a_one_item, in_valid_i && in_ready_o |=> !in_ready_o, "item taken while busy")

  // Dropped colour carries zero fields
  `FCP_ASSERT_IMP(a_drop_zero, out_valid_o && !out_data_o.placed, out_data_o.pos_x == '0 && out_data_o.pos_y == '0 && out_data_o.placed_color == '0, "dropped item has fields set")

  // A result follows an accepted item, never the same edge
  `FCP_ASSERT(a_no_early, in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o, "result before work done")

endmodule

bind frontier_color_placement fcp_checker u_fcp_checker (.*);
